// ----- rtl/gem_pkg.sv -----
`timescale 1ns / 1ps
package gem_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 3;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 13;
   localparam int WEIGHT_W   = 16;
   localparam int THR_W      = 26;
   localparam int CSR_DATA_W = 26;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_CONC_WEIGHT    = 2'd2,
      CSR_EDGE_THRESHOLD = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } point_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               v;
   } normal_type;

   typedef struct packed {
      point_type  p;
      normal_type n;
   } cell_type;

   // one line-store entry: rows r-2 and r-1 of a column
   typedef struct packed {
      cell_type upper;
      cell_type middle;
   } line_type;

   localparam int CELL_W = $bits(cell_type);
   localparam int LINE_W = $bits(line_type);

   // control between sequencer and neighbor unit
   typedef struct packed {
      logic start;
   } eval_ctl_type;

   typedef struct packed {
      logic done;
      logic smooth;
   } eval_sts_type;

endpackage

// ----- rtl/gem_req_if.sv -----
`timescale 1ns / 1ps
interface gem_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] point_z;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic               normal_valid;

   modport source (output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                   normal_valid, input ready);
   modport sink (input valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                 normal_valid, output ready);
endinterface

// ----- rtl/gem_rsp_if.sv -----
`timescale 1ns / 1ps
interface gem_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  pixel_col;
   logic [11:0] pixel_row;
   logic        smooth;
   logic        frame_last;

   modport source (output valid, pixel_col, pixel_row, smooth, frame_last, input ready);
   modport sink (input valid, pixel_col, pixel_row, smooth, frame_last, output ready);
endinterface

// ----- rtl/gem_ram.sv -----
`timescale 1ns / 1ps
module gem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/gem_nbr_unit.sv -----
`timescale 1ns / 1ps
module gem_nbr_unit import gem_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  eval_ctl_type        ctl,
   input  cell_type [8:0]      grid,
   input  logic [WEIGHT_W-1:0] weight,
   input  logic [THR_W-1:0]    threshold,
   output eval_sts_type        sts
);
   localparam logic signed [34:0] INVALID_RAW = -(35'sd1 <<< 24);
   localparam logic signed [34:0] ONE_Q28     = 35'sd1 <<< 28;

   // neighbor index 0..7 to grid slot, skipping the center
   function automatic logic [3:0] nbr_slot(input logic [2:0] idx);
      nbr_slot = (idx < 3'd4) ? {1'b0, idx} : ({1'b0, idx} + 4'd1);
   endfunction

   logic        run_ff, run_in;
   logic [2:0]  idx_ff, idx_in;

   logic                      s1_vld_ff, s1_first_ff, s1_last_ff, s1_inv_ff;
   logic signed [32:0]        pd_ff [3];
   logic signed [31:0]        pn_ff [3];

   logic signed [34:0] maxd_ff, maxc_ff;
   logic               fin_ff, mul_ff;
   logic signed [51:0] wprod_ff;
   logic               done_ff, ne_ff;

   cell_type           ctr, nbr;
   logic signed [16:0] diff [3];
   logic signed [34:0] raw, raw_abs, conc, dotn;

   assign ctr = grid[4];
   assign nbr = grid[nbr_slot(idx_ff)];

   always_comb begin
      diff[0] = {nbr.p.x[15], nbr.p.x} - {ctr.p.x[15], ctr.p.x};
      diff[1] = {nbr.p.y[15], nbr.p.y} - {ctr.p.y[15], ctr.p.y};
      diff[2] = {nbr.p.z[15], nbr.p.z} - {ctr.p.z[15], ctr.p.z};
   end

   always_comb begin
      run_in = run_ff;
      idx_in = idx_ff;
      if (ctl.start) begin
         run_in = 1'b1;
         idx_in = '0;
      end else if (run_ff) begin
         idx_in = idx_ff + 3'd1;
         if (idx_ff == 3'd7) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         idx_ff    <= '0;
         s1_vld_ff <= 1'b0;
         fin_ff    <= 1'b0;
         mul_ff    <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         run_ff    <= run_in;
         idx_ff    <= idx_in;
         s1_vld_ff <= run_ff;
         fin_ff    <= s1_vld_ff && s1_last_ff;
         mul_ff    <= fin_ff;
         done_ff   <= mul_ff;
      end
   end

   // stage 1: products for one neighbor
   always_ff @(posedge clock) begin
      s1_first_ff <= (idx_ff == 3'd0);
      s1_last_ff  <= (idx_ff == 3'd7);
      s1_inv_ff   <= !ctr.n.v || !nbr.n.v;
      pd_ff[0]    <= ctr.n.x * diff[0];
      pd_ff[1]    <= ctr.n.y * diff[1];
      pd_ff[2]    <= ctr.n.z * diff[2];
      pn_ff[0]    <= ctr.n.x * nbr.n.x;
      pn_ff[1]    <= ctr.n.y * nbr.n.y;
      pn_ff[2]    <= ctr.n.z * nbr.n.z;
   end

   // stage 2: sums and running maxima
   always_comb begin
      raw     = s1_inv_ff ? INVALID_RAW
                          : (35'(pd_ff[0]) + 35'(pd_ff[1]) + 35'(pd_ff[2]));
      dotn    = 35'(pn_ff[0]) + 35'(pn_ff[1]) + 35'(pn_ff[2]);
      raw_abs = raw[34] ? -raw : raw;
      conc    = raw[34] ? '0 : (ONE_Q28 - dotn);
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         if (s1_first_ff || raw_abs > maxd_ff) begin
            maxd_ff <= raw_abs;
         end
         if (s1_first_ff || conc > maxc_ff) begin
            maxc_ff <= conc;
         end
      end
      if (fin_ff) begin
         wprod_ff <= $signed({1'b0, weight}) * maxc_ff;
      end
      if (mul_ff) begin
         // maxd*2^20 + lambda*maxc <= thr*2^24
         ne_ff <= ($signed({4'b0, maxd_ff[33:0], 20'b0}) + 58'(wprod_ff))
                  <= $signed({8'b0, threshold, 24'b0});
      end
   end

   assign sts.done   = done_ff;
   assign sts.smooth = ne_ff;
endmodule

// ----- rtl/geometric_edge_map.sv -----
`timescale 1ns / 1ps
// Geometric edge map. Pixels (3-D point Q5.10, normal Q1.14 with valid flag)
// arrive in raster order on req; for every interior pixel one item leaves on
// rsp with its column, row, smooth (1 = smooth surface) and frame_last. A pixel
// (c-1, r-1) is decided when pixel (c, r) arrives; border rows and columns
// produce no item. Every pixel takes one line-store read; one that decides
// a pixel then uses a shared neighbor unit that scores the eight neighbors
// one per cycle over a two-stage multiply and max pipeline, followed by the
// lambda multiply and the compare.
// The finished item waits in an output register while the next pixel is taken.
// The line store is one 1024-entry RAM holding rows r-2 and r-1 per column;
// it is not cleared. Width and height are clamped to [3, 1024] and [3, 4096];
// write configuration only while the block is idle.
module geometric_edge_map import gem_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   gem_req_if.sink               req,
   gem_rsp_if.source             rsp,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RD   = 4'b0010,
      S_EVAL = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [IMG_W_W-1:0]  img_w_ff;
   logic [IMG_H_W-1:0]  img_h_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [THR_W-1:0]    thr_ff;
   logic [IMG_W_W-1:0]  w_eff;
   logic [IMG_H_W-1:0]  h_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= IMG_W_W'(640);
         img_h_ff  <= IMG_H_W'(480);
         weight_ff <= WEIGHT_W'(3277);
         thr_ff    <= THR_W'(1049);
      end else if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_IMAGE_WIDTH:    img_w_ff  <= csr_wdata[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT:   img_h_ff  <= csr_wdata[IMG_H_W-1:0];
            CSR_CONC_WEIGHT:    weight_ff <= csr_wdata[WEIGHT_W-1:0];
            CSR_EDGE_THRESHOLD: thr_ff    <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = img_w_ff;
      if (img_w_ff < IMG_W_W'(MIN_DIM))   w_eff = IMG_W_W'(MIN_DIM);
      if (img_w_ff > IMG_W_W'(MAX_WIDTH)) w_eff = IMG_W_W'(MAX_WIDTH);
      h_eff = img_h_ff;
      if (img_h_ff < IMG_H_W'(MIN_DIM))    h_eff = IMG_H_W'(MIN_DIM);
      if (img_h_ff > IMG_H_W'(MAX_HEIGHT)) h_eff = IMG_H_W'(MAX_HEIGHT);
   end

   // raster position
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] cur_c_ff, cur_c_in;
   logic [ROW_W-1:0] cur_r_ff, cur_r_in;
   logic [ROW_W:0]   row_tmp, row_nx;
   logic [COL_W:0]   col_nx;
   logic             accept, interior;

   assign accept   = req.valid && req.ready;
   assign interior = (cur_c_ff >= COL_W'(2)) && (cur_r_ff >= ROW_W'(2));

   // position of the arriving pixel, wrapping if geometry shrank
   always_comb begin
      cur_c_in = col_ff;
      row_tmp  = {1'b0, row_ff};
      if ({1'b0, col_ff} >= w_eff) begin
         cur_c_in = '0;
         row_tmp  = {1'b0, row_ff} + (ROW_W+1)'(1);
      end
      cur_r_in = row_tmp[ROW_W-1:0];
      if (row_tmp >= h_eff) begin
         cur_r_in = '0;
      end
   end

   // position after this pixel
   always_comb begin
      col_nx = {1'b0, cur_c_ff} + (COL_W+1)'(1);
      row_nx = {1'b0, cur_r_ff} + (ROW_W+1)'(1);
      col_in = col_nx[COL_W-1:0];
      row_in = cur_r_ff;
      if (col_nx >= w_eff) begin
         col_in = '0;
         row_in = (row_nx >= h_eff) ? '0 : row_nx[ROW_W-1:0];
      end
   end

   // line store and 3x3 window (grid index = col*3 + row)
   cell_type       in_cell_ff;
   cell_type [8:0] grid_ff;
   line_type       rd_line, wr_line;

   assign wr_line.upper  = rd_line.middle;
   assign wr_line.middle = in_cell_ff;

   gem_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_RD),
      .wr_addr (cur_c_ff),
      .wr_data (wr_line),
      .rd_en   (accept),
      .rd_addr (cur_c_in),
      .rd_data (rd_line)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cell_ff.p.x <= req.point_x;
         in_cell_ff.p.y <= req.point_y;
         in_cell_ff.p.z <= req.point_z;
         in_cell_ff.n.x <= req.normal_x;
         in_cell_ff.n.y <= req.normal_y;
         in_cell_ff.n.z <= req.normal_z;
         in_cell_ff.n.v <= req.normal_valid;
         cur_c_ff       <= cur_c_in;
         cur_r_ff       <= cur_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (state_ff == S_RD) begin
         grid_ff[2:0] <= grid_ff[5:3];
         grid_ff[5:3] <= grid_ff[8:6];
         grid_ff[6]   <= rd_line.upper;
         grid_ff[7]   <= rd_line.middle;
         grid_ff[8]   <= in_cell_ff;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   // neighbor evaluation
   eval_ctl_type u_ctl;
   eval_sts_type u_sts;

   assign u_ctl.start = (state_ff == S_RD) && interior;

   gem_nbr_unit u_nbr (
      .clock     (clock),
      .reset     (reset),
      .ctl       (u_ctl),
      .grid      (grid_ff),
      .weight    (weight_ff),
      .threshold (thr_ff),
      .sts       (u_sts)
   );

   // output register
   logic             rsp_valid_ff, ne_hold_ff, load_out;
   logic [COL_W-1:0] out_col_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic             out_ne_ff, out_last_ff;

   assign load_out = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_RD;
         S_RD:   state_in = interior ? S_EVAL : S_IDLE;
         S_EVAL: if (u_sts.done) state_in = S_OUT;
         S_OUT:  if (load_out) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (u_sts.done) begin
         ne_hold_ff <= u_sts.smooth;
      end
      if (load_out) begin
         out_col_ff  <= cur_c_ff - COL_W'(1);
         out_row_ff  <= cur_r_ff - ROW_W'(1);
         out_ne_ff   <= ne_hold_ff;
         out_last_ff <= ({1'b0, cur_c_ff} == w_eff - IMG_W_W'(1))
                        && ({1'b0, cur_r_ff} == h_eff - IMG_H_W'(1));
      end
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pixel_col  = out_col_ff;
   assign rsp.pixel_row  = out_row_ff;
   assign rsp.smooth     = out_ne_ff;
   assign rsp.frame_last = out_last_ff;

   // checks
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_RD) else $error("accept did not start line read");

   a_done_in_eval: assert property (@(posedge clock) disable iff (reset)
      u_sts.done |-> state_ff == S_EVAL) else $error("neighbor unit done outside eval");

   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_col_ff != '0 && out_row_ff != '0))
      else $error("border pixel emitted");

   a_start_interior: assert property (@(posedge clock) disable iff (reset)
      u_ctl.start |=> state_ff == S_EVAL) else $error("evaluation start without eval");
endmodule
